// ----- hw/rtl/swc_pkg.sv -----
// Shared widths, codes and reset values for the sprite window clipper.
// No dependencies; imported by sprite_window_clipper.
package swc_pkg;

	localparam int SZ_W      = 12;               // sprite width / height
	localparam int TEX_W     = 13;               // texture width / height
	localparam int PROD_W    = SZ_W + TEX_W;     // cut * tex product
	localparam int QUO_W     = TEX_W;            // scaled cut, one divider stage per bit
	localparam int QIDX_W    = $clog2(QUO_W);
	localparam int CFG_IDX_W = 2;

	localparam int WIN_MIN_X_RST = 0;
	localparam int WIN_MIN_Y_RST = 0;
	localparam int WIN_MAX_X_RST = 1024;
	localparam int WIN_MAX_Y_RST = 768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIN_MIN_X = 2'd0,
		REG_WIN_MIN_Y = 2'd1,
		REG_WIN_MAX_X = 2'd2,
		REG_WIN_MAX_Y = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_INVISIBLE = 2'd0,
		MODE_FULL      = 2'd1,
		MODE_CLIPPED   = 2'd2
	} draw_mode_t;

endpackage

// ----- hw/rtl/sprite_window_clipper.sv -----
// Sprite window clipper: clips sprite rectangles against a window and scales
// the cuts into texture space. Depends on swc_pkg.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the window
//    edges; always ready. Write only while no sprite is in flight.
//  - Input channel (in_valid/in_ready) takes one sprite word per cycle while in_ready is high.
//  - Output channel (out_valid/out_ready) gives one result word per sprite,
//    in order.
//  - Throughput: one sprite per cycle while out_ready does not hold the pipeline.
//  - Depth: two stages of edge compares, one of multiplies, the restoring
//    divider (one quotient bit per stage, 13 stages) and the result register.
//  - All stages advance together. When the receiver holds out_ready low with
//    a word waiting, the whole pipeline freezes and in_ready drops; nothing
//    is lost or repeated.
//  - Reset empties the pipeline and loads the window 0,0 .. 1024,768.
module sprite_window_clipper
	import swc_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// config
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [COORD_WIDTH-1:0]        cfg_data,
	// sprite in
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] obj_x,
	input  logic signed [COORD_WIDTH-1:0] obj_y,
	input  logic [SZ_W-1:0]               obj_w,
	input  logic [SZ_W-1:0]               obj_h,
	input  logic [TEX_W-1:0]              tex_w,
	input  logic [TEX_W-1:0]              tex_h,
	// result out
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    draw_mode,
	output logic signed [COORD_WIDTH-1:0] dst_x,
	output logic signed [COORD_WIDTH-1:0] dst_y,
	output logic [SZ_W-1:0]               dst_w,
	output logic [SZ_W-1:0]               dst_h,
	output logic [TEX_W-1:0]              src_x,
	output logic [TEX_W-1:0]              src_y,
	output logic [TEX_W-1:0]              src_w,
	output logic [TEX_W-1:0]              src_h
);

	localparam int CW = COORD_WIDTH;
	localparam int NS = QUO_W + 4;   // s1, s2, products, divider stages, result

	typedef struct packed {
		logic signed [CW-1:0] lo;
		logic signed [CW-1:0] vlo;
		logic signed [CW-1:0] vhi;
		logic [SZ_W-1:0]      size;
		logic [TEX_W-1:0]     tex;
	} axis_edge_t;

	typedef struct packed {
		logic                 vis;
		logic                 cut;
		logic signed [CW-1:0] dpos;
		logic [SZ_W-1:0]      dsize;
		logic [SZ_W-1:0]      clo;
		logic [SZ_W-1:0]      csum;
		logic [SZ_W-1:0]      osize;
		logic [TEX_W-1:0]     tex;
	} axis_cut_t;

	typedef struct packed {
		logic signed [CW-1:0] dpos;
		logic [SZ_W-1:0]      dsize;
		logic [SZ_W-1:0]      osize;
		logic [TEX_W-1:0]     tex;
		logic [PROD_W-1:0]    rem_lo;
		logic [PROD_W-1:0]    rem_sum;
		logic [QUO_W-1:0]     q_lo;
		logic [QUO_W-1:0]     q_sum;
	} axis_div_t;

	typedef struct packed {
		logic      vis;
		logic      cut;
		axis_div_t x;
		axis_div_t y;
	} div_t;

	typedef struct packed {
		draw_mode_t           mode;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic [SZ_W-1:0]      dw;
		logic [SZ_W-1:0]      dh;
		logic [TEX_W-1:0]     sx;
		logic [TEX_W-1:0]     sy;
		logic [TEX_W-1:0]     sw;
		logic [TEX_W-1:0]     sh;
	} res_t;

	// stage 1: far edge and overlap edges
	function automatic axis_edge_t axis_front(
		input logic signed [CW-1:0] lo,
		input logic [SZ_W-1:0]      size,
		input logic [TEX_W-1:0]     tex,
		input logic signed [CW-1:0] wmin,
		input logic signed [CW-1:0] wmax
	);
		axis_edge_t         r;
		logic signed [CW:0] hi;
		logic signed [CW:0] wmax_e;
		hi     = $signed({lo[CW-1], lo}) + $signed({{(CW+1-SZ_W){1'b0}}, size});
		wmax_e = $signed({wmax[CW-1], wmax});
		r.lo   = lo;
		r.size = size;
		r.tex  = tex;
		r.vlo  = (lo > wmin) ? lo : wmin;
		r.vhi  = (hi < wmax_e) ? hi[CW-1:0] : wmax;
		return r;
	endfunction

	// stage 2: visibility and cut amounts (narrow values are exact when visible)
	function automatic axis_cut_t axis_mid(input axis_edge_t a);
		axis_cut_t   r;
		logic [CW-1:0] span;
		logic [CW-1:0] off;
		span    = a.vhi - a.vlo;
		off     = a.vlo - a.lo;
		r.vis   = (a.size != '0) && (a.vhi > a.vlo);
		r.dpos  = a.vlo;
		r.dsize = span[SZ_W-1:0];
		r.clo   = off[SZ_W-1:0];
		r.csum  = a.size - span[SZ_W-1:0];
		r.cut   = (a.size != span[SZ_W-1:0]);
		r.osize = a.size;
		r.tex   = a.tex;
		return r;
	endfunction

	function automatic axis_div_t axis_prod(input axis_cut_t a);
		axis_div_t r;
		r.dpos    = a.dpos;
		r.dsize   = a.dsize;
		r.osize   = a.osize;
		r.tex     = a.tex;
		r.rem_lo  = {{(PROD_W-SZ_W){1'b0}}, a.clo} * {{(PROD_W-TEX_W){1'b0}}, a.tex};
		r.rem_sum = {{(PROD_W-SZ_W){1'b0}}, a.csum} * {{(PROD_W-TEX_W){1'b0}}, a.tex};
		r.q_lo    = '0;
		r.q_sum   = '0;
		return r;
	endfunction

	// one restoring-division bit for both dividends of an axis
	function automatic axis_div_t axis_step(input axis_div_t a, input logic [QIDX_W-1:0] b);
		axis_div_t       r;
		logic [PROD_W:0] dsh;
		r   = a;
		dsh = {{(PROD_W+1-SZ_W){1'b0}}, a.osize} << b;
		if ({1'b0, a.rem_lo} >= dsh) begin
			r.rem_lo  = a.rem_lo - dsh[PROD_W-1:0];
			r.q_lo[b] = 1'b1;
		end
		if ({1'b0, a.rem_sum} >= dsh) begin
			r.rem_sum  = a.rem_sum - dsh[PROD_W-1:0];
			r.q_sum[b] = 1'b1;
		end
		return r;
	endfunction

	logic signed [CW-1:0] win_min_x_q, win_min_y_q, win_max_x_q, win_max_y_q;

	logic       adv;
	logic [NS-1:0] valid_s;
	axis_edge_t x_s1, y_s1;
	axis_cut_t  x_s2, y_s2;
	div_t       div_s [QUO_W+1];
	div_t       div_d [QUO_W+1];
	res_t       res_s;
	res_t       res_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_min_x_q <= CW'(WIN_MIN_X_RST);
			win_min_y_q <= CW'(WIN_MIN_Y_RST);
			win_max_x_q <= CW'(WIN_MAX_X_RST);
			win_max_y_q <= CW'(WIN_MAX_Y_RST);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WIN_MIN_X: win_min_x_q <= cfg_data;
				REG_WIN_MIN_Y: win_min_y_q <= cfg_data;
				REG_WIN_MAX_X: win_max_x_q <= cfg_data;
				REG_WIN_MAX_Y: win_max_y_q <= cfg_data;
			endcase
		end
	end

	// whole pipeline moves unless a finished word is held at the output
	assign adv      = !valid_s[NS-1] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[NS-2:0], in_valid};
		end
	end

	always_comb begin
		div_d[0].vis = x_s2.vis && y_s2.vis;
		div_d[0].cut = x_s2.cut || y_s2.cut;
		div_d[0].x   = axis_prod(x_s2);
		div_d[0].y   = axis_prod(y_s2);
		for (int k = 0; k < QUO_W; k++) begin
			div_d[k+1].vis = div_s[k].vis;
			div_d[k+1].cut = div_s[k].cut;
			div_d[k+1].x   = axis_step(div_s[k].x, QIDX_W'(QUO_W - 1 - k));
			div_d[k+1].y   = axis_step(div_s[k].y, QIDX_W'(QUO_W - 1 - k));
		end
	end

	always_comb begin
		res_d = '0;
		if (div_s[QUO_W].vis) begin
			res_d.mode = div_s[QUO_W].cut ? MODE_CLIPPED : MODE_FULL;
			res_d.dx   = div_s[QUO_W].x.dpos;
			res_d.dy   = div_s[QUO_W].y.dpos;
			res_d.dw   = div_s[QUO_W].x.dsize;
			res_d.dh   = div_s[QUO_W].y.dsize;
			res_d.sx   = div_s[QUO_W].x.q_lo;
			res_d.sy   = div_s[QUO_W].y.q_lo;
			res_d.sw   = div_s[QUO_W].x.tex - div_s[QUO_W].x.q_sum;
			res_d.sh   = div_s[QUO_W].y.tex - div_s[QUO_W].y.q_sum;
		end else begin
			res_d.mode = MODE_INVISIBLE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= axis_front(obj_x, obj_w, tex_w, win_min_x_q, win_max_x_q);
			y_s1 <= axis_front(obj_y, obj_h, tex_h, win_min_y_q, win_max_y_q);
			x_s2 <= axis_mid(x_s1);
			y_s2 <= axis_mid(y_s1);
			for (int k = 0; k <= QUO_W; k++) begin
				div_s[k] <= div_d[k];
			end
			res_s <= res_d;
		end
	end

	assign out_valid = valid_s[NS-1];
	assign draw_mode = res_s.mode;
	assign dst_x     = res_s.dx;
	assign dst_y     = res_s.dy;
	assign dst_w     = res_s.dw;
	assign dst_h     = res_s.dh;
	assign src_x     = res_s.sx;
	assign src_y     = res_s.sy;
	assign src_w     = res_s.sw;
	assign src_h     = res_s.sh;

endmodule
